// ===== rtl/core/mqtt_inbound_packet_parser_unit_defines.svh =====
// Assertion macros shared by the MQTT inbound parser RTL.
// Each file that checks its own logic includes this header.
`ifndef MQTT_INBOUND_PACKET_PARSER_UNIT_DEFINES_SVH
`define MQTT_INBOUND_PACKET_PARSER_UNIT_DEFINES_SVH

// Implication checked in the same cycle, off while reset is asserted.
`define MQTTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqttp: assertion failed");

// Implication checked in the cycle after the antecedent.
`define MQTTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqttp: assertion failed");

`endif

// ===== rtl/core/mqttp_pkg.sv =====
// Shared types and constants of the MQTT inbound packet parser.
// No dependencies; imported by every module of the block.
package mqttp_pkg;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_LENGTH  = 3'd1,
        ROLE_TLEN    = 3'd2,
        ROLE_TOPIC   = 3'd3,
        ROLE_VALUE   = 3'd4,
        ROLE_CONNACK = 3'd5,
        ROLE_SKIP    = 3'd6,
        ROLE_DISCARD = 3'd7
    } t_role;

    typedef enum logic [1:0] {
        LINK_CONNECTING = 2'd0,
        LINK_CONNACKED  = 2'd1,
        LINK_UNKNOWN    = 2'd2,
        LINK_STREAM_ERR = 2'd3
    } t_link;

    localparam logic [3:0] KIND_CONNACK = 4'd2;
    localparam logic [3:0] KIND_PUBLISH = 4'd3;

    localparam int unsigned LEN_W   = 28;
    localparam int unsigned TOPIC_W = 16;

    typedef struct packed {
        logic [7:0] byte_out;
        t_role      role;
        logic [3:0] kind;
        logic       pkt_end;
        t_link      status;
        logic [7:0] ret_code;
    } t_result;

endpackage

// ===== rtl/core/mqttp_in_stage.sv =====
// Input register of the MQTT inbound parser: holds one received byte.
// Depends on mqttp_pkg.
module mqttp_in_stage
    import mqttp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_take,
    output logic       o_advance,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready   = !r_valid || i_take;
    assign o_advance = r_valid && i_take;
    assign o_byte    = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== rtl/core/mqttp_parse.sv =====
// Parser state and per-byte decode of the MQTT inbound packet parser.
// Depends on mqttp_pkg and the assertion macros header.
`include "mqtt_inbound_packet_parser_unit_defines.svh"

module mqttp_parse
    import mqttp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_VALUE   = 3'd5,
        PH_CONNACK = 3'd6,
        PH_SKIP    = 3'd7
    } t_phase;

    t_phase               r_phase,   n_phase;
    logic [LEN_W-1:0]     r_left,    n_left;
    logic [1:0]           r_vcount,  n_vcount;
    logic [3:0]           r_kind,    n_kind;
    logic [TOPIC_W-1:0]   r_tleft,   n_tleft;
    logic [7:0]           r_thigh,   n_thigh;
    logic                 r_len2,    n_len2;
    t_link                r_link,    n_link;
    logic [7:0]           r_ack,     n_ack;

    t_role                role;
    logic                 pkt_end;
    logic [LEN_W-1:0]     group;
    logic [LEN_W-1:0]     left_or;
    logic [LEN_W-1:0]     left_dec;
    logic [TOPIC_W-1:0]   tcount;
    logic [TOPIC_W-1:0]   tleft_dec;

    always_comb begin
        case (r_vcount)
            2'd0:    group = {21'd0, i_byte[6:0]};
            2'd1:    group = {14'd0, i_byte[6:0], 7'd0};
            2'd2:    group = {7'd0, i_byte[6:0], 14'd0};
            default: group = {i_byte[6:0], 21'd0};
        endcase
    end

    assign left_or   = r_left | group;
    assign left_dec  = r_left - LEN_W'(1);
    assign tcount    = {r_thigh, i_byte};
    assign tleft_dec = r_tleft - TOPIC_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_left   = r_left;
        n_vcount = r_vcount;
        n_kind   = r_kind;
        n_tleft  = r_tleft;
        n_thigh  = r_thigh;
        n_len2   = r_len2;
        n_link   = r_link;
        n_ack    = r_ack;
        role     = ROLE_DISCARD;
        pkt_end  = 1'b0;

        if (r_link == LINK_STREAM_ERR) begin
            role = ROLE_DISCARD;
        end else if (r_phase == PH_HEADER) begin
            role     = ROLE_HEADER;
            n_kind   = i_byte[7:4];
            n_left   = '0;
            n_vcount = 2'd0;
            n_phase  = PH_LENGTH;
        end else if (r_phase == PH_LENGTH) begin
            if (r_vcount == 2'd3 && i_byte[7]) begin
                role   = ROLE_DISCARD;
                n_link = LINK_STREAM_ERR;
            end else begin
                role   = ROLE_LENGTH;
                n_left = left_or;
                if (i_byte[7]) begin
                    n_vcount = r_vcount + 2'd1;
                end else begin
                    n_vcount = 2'd0;
                    n_len2   = (left_or == LEN_W'(2));
                    if (left_or == '0) begin
                        pkt_end = 1'b1;
                        n_phase = PH_HEADER;
                        // A CONNACK of zero length is a CONNACK of the wrong length.
                        if (r_kind == KIND_CONNACK) begin
                            n_link = (r_link == LINK_CONNACKED) ? LINK_STREAM_ERR
                                                                : LINK_UNKNOWN;
                        end
                    end else if (r_kind == KIND_CONNACK) begin
                        n_phase = PH_CONNACK;
                    end else if (r_kind == KIND_PUBLISH && left_or >= LEN_W'(2)) begin
                        n_phase = PH_TLEN_HI;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
        end else begin
            n_left  = left_dec;
            pkt_end = (left_dec == '0);
            case (r_phase)
                PH_CONNACK: begin
                    role = ROLE_CONNACK;
                    if (pkt_end) begin
                        if (r_link == LINK_CONNACKED) begin
                            n_link = LINK_STREAM_ERR;
                        end else if (r_len2) begin
                            n_link = LINK_CONNACKED;
                            n_ack  = i_byte;
                        end else begin
                            n_link = LINK_UNKNOWN;
                        end
                    end
                end
                PH_SKIP: begin
                    role = ROLE_SKIP;
                end
                PH_TLEN_HI: begin
                    role    = ROLE_TLEN;
                    n_thigh = i_byte;
                    n_phase = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    role = ROLE_TLEN;
                    // An overrunning topic length leaves the topic empty.
                    if (tcount != '0 && {12'd0, tcount} <= left_dec) begin
                        n_tleft = tcount;
                        n_phase = PH_TOPIC;
                    end else begin
                        n_tleft = '0;
                        n_phase = PH_VALUE;
                    end
                end
                PH_TOPIC: begin
                    role    = ROLE_TOPIC;
                    n_tleft = tleft_dec;
                    if (tleft_dec == '0) begin
                        n_phase = PH_VALUE;
                    end
                end
                default: begin
                    role = ROLE_VALUE;
                end
            endcase
            if (pkt_end) begin
                n_phase = PH_HEADER;
            end
        end
    end

    always_comb begin
        o_result.byte_out = i_byte;
        o_result.role     = role;
        o_result.kind     = n_kind;
        o_result.pkt_end  = pkt_end;
        o_result.status   = n_link;
        o_result.ret_code = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_left   <= '0;
            r_vcount <= 2'd0;
            r_kind   <= 4'd0;
            r_tleft  <= '0;
            r_thigh  <= 8'd0;
            r_len2   <= 1'b0;
            r_link   <= LINK_CONNECTING;
            r_ack    <= 8'd0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_vcount <= n_vcount;
            r_kind   <= n_kind;
            r_tleft  <= n_tleft;
            r_thigh  <= n_thigh;
            r_len2   <= n_len2;
            r_link   <= n_link;
            r_ack    <= n_ack;
        end
    end

    `MQTTP_ASSERT_NEXT(a_stream_err_sticky, i_clk, i_rst_n,
        r_link == LINK_STREAM_ERR, r_link == LINK_STREAM_ERR)
    `MQTTP_ASSERT_NOW(a_vcount_in_length, i_clk, i_rst_n,
        r_vcount != 2'd0, r_phase == PH_LENGTH)
    `MQTTP_ASSERT_NOW(a_topic_nonempty, i_clk, i_rst_n,
        r_phase == PH_TOPIC && r_link != LINK_STREAM_ERR, r_tleft != '0)
    `MQTTP_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n,
        !i_advance, $stable(r_phase) && $stable(r_left) && $stable(r_link))

endmodule

// ===== rtl/core/mqttp_out_stage.sv =====
// Result register of the MQTT inbound parser: holds one tagged byte.
// Depends on mqttp_pkg.
module mqttp_out_stage
    import mqttp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== rtl/core/mqtt_inbound_packet_parser_unit.sv =====
// MQTT inbound packet parser: tags each received byte with its role in the packet.
// A byte passes one input register, one decode pass and one result register to the ports.
// Throughput: one byte per cycle while the result register is empty or i_out_ready is high.
// Reset (synchronous, active low) empties both registers, returns the parser to
// expecting a header byte and sets the connection status to connecting.
module mqtt_inbound_packet_parser_unit
    import mqttp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_role,
    output logic [3:0] o_packet_kind,
    output logic       o_packet_end,
    output logic [1:0] o_conn_status,
    output logic [7:0] o_return_code
);

    logic       out_free;
    logic       advance;
    logic [7:0] held_byte;
    t_result    step_result;
    t_result    out_result;

    mqttp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx_valid),
        .i_byte    (i_rx_byte),
        .o_ready   (o_rx_ready),
        .i_take    (out_free),
        .o_advance (advance),
        .o_byte    (held_byte)
    );

    mqttp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (held_byte),
        .o_result  (step_result)
    );

    mqttp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_byte_out    = out_result.byte_out;
    assign o_byte_role   = out_result.role;
    assign o_packet_kind = out_result.kind;
    assign o_packet_end  = out_result.pkt_end;
    assign o_conn_status = out_result.status;
    assign o_return_code = out_result.ret_code;

endmodule
